// ===== hdl/sph_pair_kernel_eval_core_macros.svh =====
// Assertion macros shared by the pair kernel evaluator RTL.
`ifndef SPH_PAIR_KERNEL_EVAL_CORE_MACROS_SVH
`define SPH_PAIR_KERNEL_EVAL_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPKE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPKE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spke_pkg.sv =====
// Shared types and constants of the pair kernel evaluator.
package spke_pkg;

  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 32;
  localparam int NumW      = 125;
  localparam int DenW      = 95;

  typedef enum logic [2:0] {
    REG_RADIUS,
    REG_RADIUS_SQ,
    REG_POLY6_COEFF,
    REG_POLY6_SHIFT,
    REG_SPIKY_COEFF,
    REG_SPIKY_SHIFT
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][30:0] mag;
    logic [2:0]       neg;
    logic             far;
  } pair_t;

  typedef struct packed {
    pair_t       pair;
    logic [31:0] weight;
    logic        wsat;
  } sq_side_t;

  typedef struct packed {
    logic [2:0]  neg;
    logic        in_support;
    logic [31:0] weight;
    logic        wsat;
  } div_side_t;

endpackage

// ===== hdl/spke_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module spke_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [63:0]         in_n,
  input  spke_pkg::sq_side_t  in_side,
  output logic                out_valid,
  output logic [31:0]         out_root,
  output spke_pkg::sq_side_t  out_side
);
  import spke_pkg::*;

  logic        v    [SqrtSteps];
  logic [63:0] rem  [SqrtSteps];
  logic [63:0] res  [SqrtSteps];
  sq_side_t    side [SqrtSteps];

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
    localparam logic [63:0] Bit = 64'(1) << (62 - 2 * i);
    logic        cur_v;
    logic [63:0] cur_rem;
    logic [63:0] cur_res;
    sq_side_t    cur_side;
    logic [63:0] trial;

    if (i == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rem  = in_n;
      assign cur_res  = '0;
      assign cur_side = in_side;
    end else begin : g_rest
      assign cur_v    = v[i-1];
      assign cur_rem  = rem[i-1];
      assign cur_res  = res[i-1];
      assign cur_side = side[i-1];
    end

    assign trial = cur_res + Bit;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (adv) begin
        v[i] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[i] <= cur_side;
        if (cur_rem >= trial) begin
          rem[i] <= cur_rem - trial;
          res[i] <= (cur_res >> 1) + Bit;
        end else begin
          rem[i] <= cur_rem;
          res[i] <= cur_res >> 1;
        end
      end
    end
  end

  assign out_valid = v[SqrtSteps-1];
  assign out_root  = res[SqrtSteps-1][31:0];
  assign out_side  = side[SqrtSteps-1];

endmodule

// ===== hdl/spke_div.sv =====
// Pipelined three-lane restoring divider with a shared divisor.
module spke_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [2:0][spke_pkg::NumW-1:0]      in_num,
  input  logic [spke_pkg::DenW-1:0]           in_den,
  input  spke_pkg::div_side_t                 in_side,
  output logic                                out_valid,
  output logic [2:0][31:0]                    out_quo,
  output logic [2:0]                          out_ovf,
  output spke_pkg::div_side_t                 out_side
);
  import spke_pkg::*;

  logic                      v    [DivSteps+1];
  logic [2:0][NumW-1:0]      rem  [DivSteps+1];
  logic [2:0][31:0]          quo  [DivSteps+1];
  logic [2:0]                ovf  [DivSteps+1];
  logic [DenW-1:0]           den  [DivSteps+1];
  div_side_t                 side [DivSteps+1];

  logic [2:0] ovf_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ovf_next[k] = {2'b00, in_num[k][NumW-1:32]} >= in_den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= in_num;
      quo[0]  <= '0;
      ovf[0]  <= ovf_next;
      den[0]  <= in_den;
      side[0] <= in_side;
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    localparam int Sh = DivSteps - 1 - i;
    logic [NumW+1:0]      dsh;
    logic [2:0]           take;
    logic [2:0][NumW-1:0] rem_next;

    assign dsh = {{(NumW + 2 - DenW){1'b0}}, den[i]} << Sh;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        take[k]     = {2'b00, rem[i][k]} >= dsh;
        rem_next[k] = take[k] ? rem[i][k] - dsh[NumW-1:0] : rem[i][k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1]  <= rem_next;
        ovf[i+1]  <= ovf[i];
        den[i+1]  <= den[i];
        side[i+1] <= side[i];
        for (int k = 0; k < 3; k++) begin
          quo[i+1][k] <= {quo[i][k][30:0], take[k]};
        end
      end
    end
  end

  assign out_valid = v[DivSteps];
  assign out_quo   = quo[DivSteps];
  assign out_ovf   = ovf[DivSteps];
  assign out_side  = side[DivSteps];

endmodule

// ===== hdl/sph_pair_kernel_eval_core.sv =====
// Top level of the SPH pair kernel evaluator: poly6 weight and spiky gradient.
//
// Input channel: in_valid/in_stall carry one particle pair (two Q16.16 positions).
// Output channel: out_valid/out_stall carry the poly6 weight, the three spiky
// gradient components and a saturation flag, one result per pair, in order.
// Configuration: cfg_wen with cfg_index and cfg_data writes one register per
// cycle; write only while no pair is in flight. Unknown indexes are ignored.
// Throughput: one pair per cycle while the receiver does not stall. The pipeline
// depth comes from the 32-stage square root, the 33-stage divider that forms the
// gradient and the multiplier stages around them.
// When the receiver stalls a valid result, the whole pipeline holds and in_stall
// rises in the same cycle; bubbles in flight do not block new input otherwise.
// Reset (rst, synchronous) empties the pipeline and loads radius and radius_sq
// with 1.0 and the coefficients and shifts with zero.
`include "sph_pair_kernel_eval_core_macros.svh"

module sph_pair_kernel_eval_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] first_x,
  input  logic signed [31:0] first_y,
  input  logic signed [31:0] first_z,
  input  logic signed [31:0] second_x,
  input  logic signed [31:0] second_y,
  input  logic signed [31:0] second_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        density_weight,
  output logic signed [31:0] grad_x,
  output logic signed [31:0] grad_y,
  output logic signed [31:0] grad_z,
  output logic               saturated
);
  import spke_pkg::*;

  logic [30:0] radius;
  logic [31:0] radius_sq;
  logic [31:0] poly6_coeff;
  logic [5:0]  poly6_shift;
  logic [31:0] spiky_coeff;
  logic [5:0]  spiky_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= 31'd65536;
      radius_sq   <= 32'd65536;
      poly6_coeff <= '0;
      poly6_shift <= '0;
      spiky_coeff <= '0;
      spiky_shift <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_RADIUS:      radius      <= cfg_data[30:0];
        REG_RADIUS_SQ:   radius_sq   <= cfg_data;
        REG_POLY6_COEFF: poly6_coeff <= cfg_data;
        REG_POLY6_SHIFT: poly6_shift <= cfg_data[5:0];
        REG_SPIKY_COEFF: spiky_coeff <= cfg_data;
        REG_SPIKY_SHIFT: spiky_shift <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [32:0] diff [3];
  logic [32:0]        absd [3];
  pair_t              pair_next;

  assign pa = '{first_x, first_y, first_z};
  assign pb = '{second_x, second_y, second_z};

  always_comb begin
    pair_next.far = 1'b0;
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({pa[k][31], pa[k]}) - $signed({pb[k][31], pb[k]});
      absd[k] = diff[k][32] ? 33'(-diff[k]) : 33'(diff[k]);
      pair_next.mag[k] = absd[k][30:0];
      pair_next.neg[k] = !diff[k][32] && (diff[k] != '0);
      pair_next.far = pair_next.far | absd[k][32] | absd[k][31];
    end
  end

  logic a_valid, b_valid, c_valid, d_valid, e_valid, f_valid, g_valid, h_valid;
  logic i_valid, j_valid;
  pair_t a_pair, b_pair, c_pair, d_pair, e_pair, f_pair, g_pair, h_pair, i_pair;
  logic [2:0][61:0] b_sq;
  logic [63:0] c_s, d_s, e_s, f_s, g_s, h_s, i_s, j_s;
  logic        d_in, e_in, f_in, g_in, h_in, i_in;
  logic [31:0] d_x, e_x;
  logic [63:0] e_x2, f_lo, f_hi, h_p0, h_p1, h_p2;
  logic [95:0] g_x3;
  logic [127:0] i_v;
  sq_side_t     j_side;

  logic [47:0]  lim2;
  logic [63:0]  gap;
  logic [127:0] i_sh;

  assign lim2 = {radius_sq, 16'b0};
  assign gap  = {16'b0, lim2} - c_s;
  assign i_sh = i_v >> poly6_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0; b_valid <= 1'b0; c_valid <= 1'b0; d_valid <= 1'b0;
      e_valid <= 1'b0; f_valid <= 1'b0; g_valid <= 1'b0; h_valid <= 1'b0;
      i_valid <= 1'b0; j_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid; b_valid <= a_valid; c_valid <= b_valid; d_valid <= c_valid;
      e_valid <= d_valid; f_valid <= e_valid; g_valid <= f_valid; h_valid <= g_valid;
      i_valid <= h_valid; j_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pair <= pair_next;

      b_pair <= a_pair;
      for (int k = 0; k < 3; k++) begin
        b_sq[k] <= 62'(a_pair.mag[k]) * 62'(a_pair.mag[k]);
      end

      c_pair <= b_pair;
      c_s    <= 64'(b_sq[0]) + 64'(b_sq[1]) + 64'(b_sq[2]);

      d_pair <= c_pair;
      d_s    <= c_s;
      d_in   <= !c_pair.far && (c_s < {16'b0, lim2});
      d_x    <= gap[47:16];

      e_pair <= d_pair;
      e_s    <= d_s;
      e_in   <= d_in;
      e_x    <= d_x;
      e_x2   <= 64'(d_x) * 64'(d_x);

      f_pair <= e_pair;
      f_s    <= e_s;
      f_in   <= e_in;
      f_lo   <= 64'(e_x2[31:0]) * 64'(e_x);
      f_hi   <= 64'(e_x2[63:32]) * 64'(e_x);

      g_pair <= f_pair;
      g_s    <= f_s;
      g_in   <= f_in;
      g_x3   <= {f_hi, 32'b0} + {32'b0, f_lo};

      h_pair <= g_pair;
      h_s    <= g_s;
      h_in   <= g_in;
      h_p0   <= 64'(g_x3[31:0]) * 64'(poly6_coeff);
      h_p1   <= 64'(g_x3[63:32]) * 64'(poly6_coeff);
      h_p2   <= 64'(g_x3[95:64]) * 64'(poly6_coeff);

      i_pair <= h_pair;
      i_s    <= h_s;
      i_in   <= h_in;
      i_v    <= {64'b0, h_p0} + {32'b0, h_p1, 32'b0} + {h_p2, 64'b0};

      j_side.pair   <= i_pair;
      j_s           <= i_s;
      j_side.wsat   <= i_in && (i_sh[127:32] != '0);
      if (!i_in) begin
        j_side.weight <= '0;
      end else if (i_sh[127:32] != '0) begin
        j_side.weight <= '1;
      end else begin
        j_side.weight <= i_sh[31:0];
      end
    end
  end

  logic        sq_valid;
  logic [31:0] sq_root;
  sq_side_t    sq_side;

  spke_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (j_valid),
    .in_n      (j_s),
    .in_side   (j_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic k_valid, l_valid, m_valid, n_valid, o_valid, p_valid;
  sq_side_t k_side, l_side, m_side, n_side, o_side;
  logic     k_in, l_in, m_in, n_in, o_in;
  logic [30:0] k_r, l_r, m_r, n_r, o_r;
  logic [30:0] k_x;
  logic [61:0] l_x2;
  logic [62:0] m_pl, m_ph;
  logic [93:0] n_y;
  logic [2:0][62:0] o_p0, o_p1;
  logic [2:0][60:0] o_p2;
  logic [2:0][NumW-1:0] p_num;
  logic [DenW-1:0]      p_den;
  div_side_t            p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_valid <= 1'b0; l_valid <= 1'b0; m_valid <= 1'b0;
      n_valid <= 1'b0; o_valid <= 1'b0; p_valid <= 1'b0;
    end else if (adv) begin
      k_valid <= sq_valid; l_valid <= k_valid; m_valid <= l_valid;
      n_valid <= m_valid; o_valid <= n_valid; p_valid <= o_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_side <= sq_side;
      k_in   <= !sq_side.pair.far && (sq_root != '0) && (sq_root < {1'b0, radius});
      k_r    <= sq_root[30:0];
      k_x    <= radius - sq_root[30:0];

      l_side <= k_side;
      l_in   <= k_in;
      l_r    <= k_r;
      l_x2   <= 62'(k_x) * 62'(k_x);

      m_side <= l_side;
      m_in   <= l_in;
      m_r    <= l_r;
      m_pl   <= 63'(l_x2[30:0]) * 63'(spiky_coeff);
      m_ph   <= 63'(l_x2[61:31]) * 63'(spiky_coeff);

      n_side <= m_side;
      n_in   <= m_in;
      n_r    <= m_r;
      n_y    <= {31'b0, m_pl} + {m_ph, 31'b0};

      o_side <= n_side;
      o_in   <= n_in;
      o_r    <= n_r;
      for (int k = 0; k < 3; k++) begin
        o_p0[k] <= 63'(n_y[31:0]) * 63'(n_side.pair.mag[k]);
        o_p1[k] <= 63'(n_y[63:32]) * 63'(n_side.pair.mag[k]);
        o_p2[k] <= 61'(n_y[93:64]) * 61'(n_side.pair.mag[k]);
      end

      for (int k = 0; k < 3; k++) begin
        p_num[k] <= {62'b0, o_p0[k]} + {30'b0, o_p1[k], 32'b0} + {o_p2[k], 64'b0};
      end
      p_den             <= {64'b0, o_r} << spiky_shift;
      p_side.neg        <= o_side.pair.neg;
      p_side.in_support <= o_in;
      p_side.weight     <= o_side.weight;
      p_side.wsat       <= o_side.wsat;
    end
  end

  logic            dv_valid;
  logic [2:0][31:0] dv_quo;
  logic [2:0]      dv_ovf;
  div_side_t       dv_side;

  spke_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (p_valid),
    .in_num    (p_num),
    .in_den    (p_den),
    .in_side   (p_side),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_ovf   (dv_ovf),
    .out_side  (dv_side)
  );

  logic [2:0][31:0] lim;
  logic [2:0]       clip;
  logic [2:0][31:0] mag_c;
  logic [2:0][31:0] grad_next;
  logic             gsat;

  always_comb begin
    gsat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lim[k]   = dv_side.neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      clip[k]  = dv_ovf[k] || (dv_quo[k] > lim[k]);
      mag_c[k] = clip[k] ? lim[k] : dv_quo[k];
      if (!dv_side.in_support) begin
        grad_next[k] = '0;
      end else begin
        grad_next[k] = dv_side.neg[k] ? 32'(-mag_c[k]) : mag_c[k];
      end
      gsat = gsat | (dv_side.in_support & clip[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      density_weight <= dv_side.weight;
      grad_x         <= grad_next[0];
      grad_y         <= grad_next[1];
      grad_z         <= grad_next[2];
      saturated      <= dv_side.wsat | gsat;
    end
  end

  logic p6_off, sp_off, grad_zero;
  assign p6_off    = out_valid && (poly6_coeff == '0);
  assign sp_off    = out_valid && (spiky_coeff == '0);
  assign grad_zero = ({grad_x, grad_y, grad_z} == '0);

  `SPKE_ASSERT_NOW(a_zero_poly6, p6_off, density_weight == '0, "nonzero poly6 weight")
  `SPKE_ASSERT_NOW(a_zero_spiky, sp_off, grad_zero, "nonzero spiky gradient")
  `SPKE_ASSERT_NEXT(a_take, in_valid && !in_stall, a_valid, "transfer lost at entry")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the SPH pair kernel evaluator (poly6 weight and spiky gradient).
`timescale 1ns / 100ps

module testbench;
  import spke_pkg::*;

  localparam logic [2:0] UNUSED_IDX_A = 3'd6;
  localparam logic [2:0] UNUSED_IDX_B = 3'd7;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 5000;

  typedef struct packed {
    logic [31:0] weight;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] gz;
    logic        sat;
  } kernel_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
  logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        density_weight;
  logic signed [31:0] grad_x, grad_y, grad_z;
  logic               saturated;

  // shadow of the configuration registers
  logic [30:0] sh_radius = 31'd65536;
  logic [31:0] sh_radius_sq = 32'd65536;
  logic [31:0] sh_p6_coeff = '0;
  logic [5:0]  sh_p6_shift = '0;
  logic [31:0] sh_sp_coeff = '0;
  logic [5:0]  sh_sp_shift = '0;

  kernel_result_t expected_q[$];
  int errors = 0;
  int pairs_sent = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int burst_left = 0;
  int burst_max = 8;
  int gap_max = 4;
  int stall_mode = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  logic hold_req = 1'b0;

  always #5 clk = ~clk;

  sph_pair_kernel_eval_core u_dut (.*);

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] res, bit_v;
    res = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic kernel_result_t eval_pair(logic [2:0][31:0] p, logic [2:0][31:0] q);
    kernel_result_t res;
    logic signed [32:0] d;
    logic [32:0] magw;
    logic [31:0] mag [3];
    logic neg [3];
    logic [31:0] g [3];
    logic far;
    logic [63:0] s, lim2, r;
    logic [127:0] v, lim;
    logic [31:0] x;
    res = '0;
    far = 1'b0;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      d = $signed({p[k][31], p[k]}) - $signed({q[k][31], q[k]});
      neg[k] = (d > 0);
      magw = (d < 0) ? 33'(-d) : 33'(d);
      if (magw >= 33'h080000000) far = 1'b1;
      mag[k] = magw[31:0];
      g[k] = '0;
    end
    if (!far) begin
      for (int k = 0; k < 3; k++) s = s + {32'd0, mag[k]} * {32'd0, mag[k]};
      lim2 = {16'd0, sh_radius_sq, 16'd0};
      if (s < lim2) begin
        x = 32'((lim2 - s) >> 16);
        v = 128'(x);
        v = v * x;
        v = v * x;
        v = v * sh_p6_coeff;
        v = v >> sh_p6_shift;
        if (v > 128'hFFFFFFFF) begin
          res.sat = 1'b1;
          res.weight = 32'hFFFFFFFF;
        end else begin
          res.weight = v[31:0];
        end
      end
      r = isqrt(s);
      if (r != 0 && r < {33'd0, sh_radius}) begin
        x = 32'({33'd0, sh_radius} - r);
        for (int k = 0; k < 3; k++) begin
          v = 128'(x);
          v = v * x;
          v = v * sh_sp_coeff;
          v = v * mag[k];
          v = v / r;
          v = v >> sh_sp_shift;
          lim = neg[k] ? 128'h80000000 : 128'h7FFFFFFF;
          if (v > lim) begin
            res.sat = 1'b1;
            v = lim;
          end
          g[k] = neg[k] ? 32'(-v[31:0]) : v[31:0];
        end
      end
    end
    res.gx = g[0];
    res.gy = g[1];
    res.gz = g[2];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, exp_v, got_v);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    kernel_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (saturated) sat_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", '0, density_weight);
      end else begin
        e = expected_q.pop_front();
        if (density_weight !== e.weight) report_mismatch("density_weight", e.weight, density_weight);
        if (grad_x !== e.gx) report_mismatch("grad_x", e.gx, grad_x);
        if (grad_y !== e.gy) report_mismatch("grad_y", e.gy, grad_y);
        if (grad_z !== e.gz) report_mismatch("grad_z", e.gz, grad_z);
        if (saturated !== e.sat) report_mismatch("saturated", 32'(e.sat), 32'(saturated));
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_wen = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wen = 1'b0;
    case (idx)
      REG_RADIUS:      sh_radius = val[30:0];
      REG_RADIUS_SQ:   sh_radius_sq = val;
      REG_POLY6_COEFF: sh_p6_coeff = val;
      REG_POLY6_SHIFT: sh_p6_shift = val[5:0];
      REG_SPIKY_COEFF: sh_sp_coeff = val;
      REG_SPIKY_SHIFT: sh_sp_shift = val[5:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] rad, logic [31:0] rad_sq, logic [31:0] p6c,
                           logic [31:0] p6s, logic [31:0] spc, logic [31:0] sps);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_RADIUS_SQ, rad_sq);
    write_reg(REG_POLY6_COEFF, p6c);
    write_reg(REG_POLY6_SHIFT, p6s);
    write_reg(REG_SPIKY_COEFF, spc);
    write_reg(REG_SPIKY_SHIFT, sps);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // entered and left at a falling edge
  task automatic send_pair(logic [2:0][31:0] p, logic [2:0][31:0] q);
    if (burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, gap_max)) @(negedge clk);
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    first_x = p[0];
    first_y = p[1];
    first_z = p[2];
    second_x = q[0];
    second_y = q[1];
    second_z = q[2];
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(eval_pair(p, q));
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic end_stream();
    in_valid = 1'b0;
    burst_left = 0;
  endtask

  task automatic send_random_pair();
    logic [2:0][31:0] p, q;
    logic [31:0] span;
    int choice;
    choice = $urandom_range(0, 9);
    span = (sh_radius == 0) ? 32'd1 : {1'b0, sh_radius};
    for (int k = 0; k < 3; k++) begin
      p[k] = $urandom;
      if (choice == 0) q[k] = $urandom;
      else if (choice == 1) q[k] = p[k];
      else q[k] = p[k] + ((32'($urandom_range(0, 2 * span)) - span) >>> $urandom_range(0, 6));
    end
    send_pair(p, q);
  endtask

  function automatic logic [31:0] pick_value(logic [31:0] hi);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  task automatic random_config();
    logic [31:0] rad;
    rad = ($urandom_range(0, 3) == 0) ? pick_value(32'h7FFFFFFF) : $urandom_range(1, 32'h60000);
    write_all(rad, ($urandom_range(0, 1) == 0) ? pick_value(32'hFFFFFFFF) : (rad * rad) >> 16,
              pick_value(32'hFFFFFFFF), pick_value(32'd63),
              pick_value(32'hFFFFFFFF), pick_value(32'd63));
  endtask

  task automatic test_reset_defaults();
    logic [2:0][31:0] p, q;
    p = '0;
    q = '0;
    send_pair(p, q);
    q[0] = 32'h00008000;
    send_pair(p, q);
    q[1] = 32'hFFFF0000;
    send_pair(p, q);
    end_stream();
    drain();
  endtask

  task automatic test_directed();
    logic [2:0][31:0] p, q;
    write_all(32'h00020000, 32'h00040000, 32'h00100000, 32'd20, 32'h00200000, 32'd10);
    write_reg(UNUSED_IDX_A, 32'hFFFFFFFF);
    write_reg(UNUSED_IDX_B, 32'h00000000);
    p = '0;
    q = '0;
    send_pair(p, q);
    for (int k = 0; k < 3; k++) begin
      q = '0;
      q[k] = 32'h00010000;
      send_pair(p, q);
      q[k] = 32'hFFFF0000;
      send_pair(p, q);
    end
    p = {32'h00004000, 32'hFFFFC000, 32'h00002000};
    q = {32'hFFFFE000, 32'h00003000, 32'h00001000};
    send_pair(p, q);
    p = {3{32'h7FFFFFFF}};
    q = {3{32'h80000000}};
    send_pair(p, q);
    send_pair(q, p);
    p = {3{32'h80000000}};
    send_pair(p, q);
    q = {32'h80000000, 32'h80000000, 32'h80010000};
    send_pair(p, q);
    q = {32'h00000000, 32'h00000000, 32'h00030000};
    send_pair('0, q);
    end_stream();
    drain();
    write_all(32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd0);
    q = {32'h00000000, 32'h00000001, 32'h00000000};
    send_pair('0, q);
    q = {32'h40000000, 32'hC0000000, 32'h00000001};
    send_pair('0, q);
    q = {32'h00100000, 32'hFFF00000, 32'h00000000};
    send_pair('0, q);
    end_stream();
    drain();
    write_all(32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd63, 32'hFFFFFFFF, 32'd63);
    send_pair('0, q);
    end_stream();
    drain();
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_pair('0, q);
    end_stream();
    drain();
  endtask

  task automatic test_random_streams();
    for (int phase = 0; phase < 10; phase++) begin
      random_config();
      stall_mode = phase % 4;
      burst_max = $urandom_range(1, 40);
      gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 10);
      repeat (130) send_random_pair();
      end_stream();
      drain();
    end
  endtask

  task automatic test_backpressure();
    write_all(32'h00040000, 32'h00100000, 32'h01000000, 32'd24, 32'h00400000, 32'd16);
    stall_mode = 0;
    burst_max = 1000;
    gap_max = 0;
    hold_req = 1'b1;
    repeat (150) send_random_pair();
    end_stream();
    drain();
    stall_mode = 1;
    repeat (40) send_random_pair();
    end_stream();
    drain();
    stall_mode = 0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_directed();
    test_random_streams();
    test_backpressure();
    $display("covered %0d pairs and %0d results (%0d saturated)",
             pairs_sent, results_seen, sat_seen);
    $display("over random register settings, stall patterns and one long output hold-off");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/spke_pkg.sv
hdl/spke_isqrt.sv
hdl/spke_div.sv
hdl/sph_pair_kernel_eval_core.sv
tb/testbench.sv
